// File: rtl/wer_pkg.sv
// ----------------------------------------------------------------------------
// wer_pkg
// Shared widths, constants, FSM state type and the command/status structs
// that join the controller and the datapath of the efficiency ratio block.
// ----------------------------------------------------------------------------
package wer_pkg;

  // Field widths
  localparam int PRICE_W = 24;
  localparam int RATIO_W = 16;
  localparam int SIZE_W  = 12;
  localparam int WIN_W   = 7;

  // Window handling
  localparam int MAX_WINDOW_DEF = 64;
  localparam int DEFAULT_WINDOW = 16;
  localparam int MIN_WINDOW     = 3;

  // Divider passes: ratio quotient bits and marker size quotient bits
  localparam int Q_STEPS = 16;
  localparam int S_STEPS = 12;
  localparam int STEP_W  = $clog2(Q_STEPS);

  // Output limits
  localparam int RATIO_MAX = 32767;
  localparam int SIZE_MAX  = 2560;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DIV_Q,
    ST_MID,
    ST_DIV_S,
    ST_POST
  } wer_state_e;

  typedef struct packed {
    logic accept;      // take a new sample
    logic sweep;       // issue the next history read
    logic div_init_q;  // load divider for the ratio pass
    logic div_init_s;  // keep ratio quotient, load divider for the size pass
    logic div_step;    // one restoring division step
    logic load_out;    // load the output register
  } wer_cmd_t;

  typedef struct packed {
    logic has_result;  // the sample being offered will give a result
    logic sweep_done;  // all differences summed
    logic div_last;    // current division step is the last of its pass
  } wer_sts_t;

endpackage

// File: rtl/wer_price_if.sv
// ----------------------------------------------------------------------------
// wer_price_if
// Valid/ready channel carrying one price sample per transfer.
// ----------------------------------------------------------------------------
interface wer_price_if;

  logic                        valid;
  logic                        ready;
  logic [wer_pkg::PRICE_W-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);

endinterface

// File: rtl/wer_result_if.sv
// ----------------------------------------------------------------------------
// wer_result_if
// Valid/ready channel carrying one ratio result per transfer.
// ----------------------------------------------------------------------------
interface wer_result_if;

  logic                               valid;
  logic                               ready;
  logic signed [wer_pkg::RATIO_W-1:0] phase_ratio;
  logic        [wer_pkg::SIZE_W-1:0]  marker_size;

  modport source (output valid, output phase_ratio, output marker_size, input ready);
  modport sink   (input valid, input phase_ratio, input marker_size, output ready);

endinterface

// File: rtl/wer_ram.sv
// ----------------------------------------------------------------------------
// wer_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wer_ram #(
  parameter int WIDTH = wer_pkg::PRICE_W,
  parameter int DEPTH = wer_pkg::MAX_WINDOW_DEF + 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/wer_ctrl.sv
// ----------------------------------------------------------------------------
// wer_ctrl
// Sequencer: accept a sample, sweep the history, run the two divider passes
// and hand the result to the output register.
// ----------------------------------------------------------------------------
module wer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wer_pkg::wer_sts_t sts_i,
  output wer_pkg::wer_cmd_t cmd_o
);

  wer_pkg::wer_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wer_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      wer_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.has_result) begin
            state_d = wer_pkg::ST_SWEEP;
          end
        end
      end
      wer_pkg::ST_SWEEP: begin
        if (sts_i.sweep_done) begin
          cmd_o.div_init_q = 1'b1;
          state_d          = wer_pkg::ST_DIV_Q;
        end else begin
          cmd_o.sweep = 1'b1;
        end
      end
      wer_pkg::ST_DIV_Q: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = wer_pkg::ST_MID;
        end
      end
      wer_pkg::ST_MID: begin
        cmd_o.div_init_s = 1'b1;
        state_d          = wer_pkg::ST_DIV_S;
      end
      wer_pkg::ST_DIV_S: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = wer_pkg::ST_POST;
        end
      end
      wer_pkg::ST_POST: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = wer_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wer_pkg::ST_IDLE;
      end
    endcase
  end

  // Set on load, clear on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/wer_datapath.sv
// ----------------------------------------------------------------------------
// wer_datapath
// Window register, history pointers, difference accumulator, shared
// restoring divider and output payload registers.
// ----------------------------------------------------------------------------
module wer_datapath #(
  parameter int MAX_WINDOW = wer_pkg::MAX_WINDOW_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [wer_pkg::WIN_W-1:0]      cfg_wdata_i,
  input  logic        [wer_pkg::PRICE_W-1:0]    price_i,
  input  wer_pkg::wer_cmd_t                     cmd_i,
  output wer_pkg::wer_sts_t                     sts_o,
  output logic                                  ram_we_o,
  output logic        [$clog2(MAX_WINDOW+1)-1:0] ram_waddr_o,
  output logic        [wer_pkg::PRICE_W-1:0]    ram_wdata_o,
  output logic                                  ram_re_o,
  output logic        [$clog2(MAX_WINDOW+1)-1:0] ram_raddr_o,
  input  logic        [wer_pkg::PRICE_W-1:0]    ram_rdata_i,
  output logic signed [wer_pkg::RATIO_W-1:0]    phase_ratio_o,
  output logic        [wer_pkg::SIZE_W-1:0]     marker_size_o
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(MAX_WINDOW + 3);
  localparam int SUM_W = wer_pkg::PRICE_W + $clog2(MAX_WINDOW + 1);
  localparam int PW    = wer_pkg::PRICE_W;
  localparam int QS    = wer_pkg::Q_STEPS;

  // Control registers
  logic [wer_pkg::WIN_W-1:0] win_q;
  logic [AW-1:0]             wp_q, wp_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          remain_q, remain_d;
  logic                      rd_pend_q, rd_pend_d;
  logic [SUM_W-1:0]          den_q, den_d;

  // Payload registers
  logic [AW-1:0]                 raddr_q, raddr_d;
  logic [PW-1:0]                 newest_q, newest_d;
  logic [PW-1:0]                 prev_q, prev_d;
  logic [PW-1:0]                 mag_q, mag_d;
  logic                          neg_q, neg_d;
  logic [SUM_W-1:0]              rem_q, rem_d;
  logic [QS-1:0]                 nb_q, nb_d;
  logic [QS-1:0]                 quo_q, quo_d;
  logic [wer_pkg::STEP_W-1:0]    step_q, step_d;
  logic [wer_pkg::RATIO_W-1:0]   qratio_q, qratio_d;
  logic [wer_pkg::RATIO_W-1:0]   ratio_out_q, ratio_out_d;
  logic [wer_pkg::SIZE_W-1:0]    size_out_q, size_out_d;

  // Combinational helpers
  logic [CNT_W-1:0] count_next, cnt_avail, win_n, cnt_sel;
  logic             win_lo, win_hi;
  logic [PW-1:0]    step_diff, mag_now;
  logic             neg_now;
  logic [PW+2:0]    mag5;
  logic [SUM_W:0]   trial;
  logic             ge;
  logic [AW-1:0]    wp_prev, raddr_prev;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= wer_pkg::WIN_W'(wer_pkg::DEFAULT_WINDOW);
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Effective window and count of differences for the offered sample
  always_comb begin
    count_next = (count_q == CNT_W'(MAX_WINDOW + 2)) ? count_q : count_q + CNT_W'(1);
    cnt_avail  = count_next - CNT_W'(2);
    win_lo     = win_q < wer_pkg::WIN_W'(wer_pkg::MIN_WINDOW);
    win_hi     = 32'(win_q) > 32'(MAX_WINDOW);
    if (win_lo) begin
      win_n = CNT_W'(wer_pkg::DEFAULT_WINDOW);
    end else if (win_hi) begin
      win_n = CNT_W'(MAX_WINDOW);
    end else begin
      win_n = CNT_W'(win_q);
    end
    cnt_sel = (cnt_avail < win_n) ? cnt_avail : win_n;
  end

  // Wrapping decrements of the history pointers
  assign wp_prev    = (wp_q == '0) ? AW'(DEPTH - 1) : wp_q - AW'(1);
  assign raddr_prev = (raddr_q == '0) ? AW'(DEPTH - 1) : raddr_q - AW'(1);

  // Absolute differences
  assign step_diff = (prev_q >= ram_rdata_i) ? prev_q - ram_rdata_i : ram_rdata_i - prev_q;
  assign neg_now   = newest_q < prev_q;
  assign mag_now   = neg_now ? prev_q - newest_q : newest_q - prev_q;

  // Size pass numerator is mag * 2560 = (mag * 5) << 9
  assign mag5 = {mag_q, 2'b00} + (PW + 3)'(mag_q);

  // Restoring division step
  assign trial = {rem_q, nb_q[QS-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    wp_d        = wp_q;
    count_d     = count_q;
    remain_d    = remain_q;
    rd_pend_d   = 1'b0;
    den_d       = den_q;
    raddr_d     = raddr_q;
    newest_d    = newest_q;
    prev_d      = prev_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    rem_d       = rem_q;
    nb_d        = nb_q;
    quo_d       = quo_q;
    step_d      = step_q;
    qratio_d    = qratio_q;
    ratio_out_d = ratio_out_q;
    size_out_d  = size_out_q;

    // Take a sample: write history, advance pointer and count, arm the sweep
    if (cmd_i.accept) begin
      wp_d     = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      count_d  = count_next;
      newest_d = price_i;
      prev_d   = price_i;
      raddr_d  = wp_prev;
      if (count_q >= CNT_W'(2)) begin
        remain_d = cnt_sel;
        den_d    = '0;
      end
    end

    // Issue one history read a cycle, walking toward older samples
    if (cmd_i.sweep && (remain_q != '0)) begin
      rd_pend_d = 1'b1;
      remain_d  = remain_q - CNT_W'(1);
      raddr_d   = raddr_prev;
    end

    // Accumulate the returning difference; the last one read is the oldest
    if (rd_pend_q) begin
      den_d  = den_q + SUM_W'(step_diff);
      prev_d = ram_rdata_i;
    end

    // Ratio pass: numerator mag << 15, remainder preloaded with its high part
    if (cmd_i.div_init_q) begin
      mag_d  = mag_now;
      neg_d  = neg_now;
      rem_d  = SUM_W'(mag_now >> 1);
      nb_d   = {mag_now[0], {(QS - 1){1'b0}}};
      quo_d  = '0;
      step_d = wer_pkg::STEP_W'(wer_pkg::Q_STEPS - 1);
    end

    // Size pass: keep the ratio quotient, numerator mag * 2560
    if (cmd_i.div_init_s) begin
      qratio_d = wer_pkg::RATIO_W'(quo_q);
      rem_d    = SUM_W'(mag5 >> 3);
      nb_d     = {mag5[2:0], {(QS - 3){1'b0}}};
      quo_d    = '0;
      step_d   = wer_pkg::STEP_W'(wer_pkg::S_STEPS - 1);
    end

    // Shift in one numerator bit, subtract when it fits
    if (cmd_i.div_step) begin
      rem_d  = ge ? SUM_W'(trial - {1'b0, den_q}) : SUM_W'(trial);
      quo_d  = {quo_q[QS-2:0], ge};
      nb_d   = {nb_q[QS-2:0], 1'b0};
      step_d = step_q - wer_pkg::STEP_W'(1);
    end

    // Sign, saturate, clamp; a flat window gives zeros
    if (cmd_i.load_out) begin
      if (den_q == '0) begin
        ratio_out_d = '0;
        size_out_d  = '0;
      end else begin
        if (neg_q) begin
          ratio_out_d = ~qratio_q + wer_pkg::RATIO_W'(1);
        end else if (qratio_q[wer_pkg::RATIO_W-1]) begin
          ratio_out_d = wer_pkg::RATIO_W'(wer_pkg::RATIO_MAX);
        end else begin
          ratio_out_d = qratio_q;
        end
        if (quo_q[wer_pkg::SIZE_W-1:0] > wer_pkg::SIZE_W'(wer_pkg::SIZE_MAX)) begin
          size_out_d = wer_pkg::SIZE_W'(wer_pkg::SIZE_MAX);
        end else begin
          size_out_d = quo_q[wer_pkg::SIZE_W-1:0];
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      count_q   <= '0;
      remain_q  <= '0;
      rd_pend_q <= 1'b0;
      den_q     <= '0;
    end else begin
      wp_q      <= wp_d;
      count_q   <= count_d;
      remain_q  <= remain_d;
      rd_pend_q <= rd_pend_d;
      den_q     <= den_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    raddr_q     <= raddr_d;
    newest_q    <= newest_d;
    prev_q      <= prev_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    rem_q       <= rem_d;
    nb_q        <= nb_d;
    quo_q       <= quo_d;
    step_q      <= step_d;
    qratio_q    <= qratio_d;
    ratio_out_q <= ratio_out_d;
    size_out_q  <= size_out_d;
  end

  // History RAM hookup
  assign ram_we_o    = cmd_i.accept;
  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = price_i;
  assign ram_re_o    = cmd_i.sweep && (remain_q != '0);
  assign ram_raddr_o = raddr_q;

  // Status to the controller
  assign sts_o.has_result = count_q >= CNT_W'(2);
  assign sts_o.sweep_done = (remain_q == '0) && !rd_pend_q;
  assign sts_o.div_last   = step_q == '0;

  assign phase_ratio_o = ratio_out_q;
  assign marker_size_o = size_out_q;

endmodule

// File: rtl/windowed_efficiency_ratio.sv
// ----------------------------------------------------------------------------
// windowed_efficiency_ratio
// Efficiency ratio of a price stream over a sliding window of differences.
// Each price transfer is written into a history RAM of MAX_WINDOW+1 entries.
// From the third sample on, one result follows: the net change over the sum
// of absolute changes across the last cnt = min(N, samples - 2) differences,
// as a signed Q1.15 ratio (+1 saturates to 32767), and a marker size of
// min(|ratio| * 10, 10) in units of 1/256. A window register value below 3
// means 16, one above MAX_WINDOW means MAX_WINDOW; a write takes effect on the
// next sample. For an item with a result, the sweep reads one history entry
// per cycle through the single RAM read port, then a shared restoring
// divider retires one quotient bit per cycle, 16 for the ratio and 12 for
// the size. The output register lets the next sample enter while a result
// waits.
// ----------------------------------------------------------------------------
module windowed_efficiency_ratio #(
  parameter int MAX_WINDOW = wer_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wer_pkg::WIN_W-1:0]   cfg_wdata_i,
  wer_price_if.sink                   price_i,
  wer_result_if.source                result_o
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int AW    = $clog2(DEPTH);

  wer_pkg::wer_cmd_t cmd;
  wer_pkg::wer_sts_t sts;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [wer_pkg::PRICE_W-1:0] ram_wdata, ram_rdata;
  logic                        in_ready, out_valid;

  // Sequencer
  wer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (price_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  wer_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .price_i       (price_i.price),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .phase_ratio_o (result_o.phase_ratio),
    .marker_size_o (result_o.marker_size)
  );

  // Price history
  wer_ram #(
    .WIDTH (wer_pkg::PRICE_W),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign price_i.ready  = in_ready;
  assign result_o.valid = out_valid;

`ifndef SYNTHESIS
  // Never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!result_o.valid || result_o.ready))
    else $error("output register loaded while a result waits");

  // A zero ratio implies a zero marker size
  a_zero_ratio_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.phase_ratio == '0)) |-> (result_o.marker_size == '0))
    else $error("nonzero marker size with zero ratio");

  // Marker size stays within 2560, ten in units of 1/256
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.marker_size <= wer_pkg::SIZE_W'(wer_pkg::SIZE_MAX)))
    else $error("marker size out of range");

  // No sample is taken while the divider runs
  a_busy_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !price_i.ready)
    else $error("input ready during division");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Efficiency ratio block testbench
// Feeds price samples through the valid/ready input channel and compares
// every result transfer with a cycle-free predictor of the windowed ratio
// and marker size. A short table of directed samples and window writes comes
// first, then phases of shaped random prices under a range of window
// settings, with random idling on both channels and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_WIN       = wer_pkg::MAX_WINDOW_DEF;
  localparam int HIST_DEPTH    = MAX_WIN + 1;
  localparam int HIST_AW       = $clog2(HIST_DEPTH);
  localparam int SETTLE_CYCLES = 120;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_A     = 100;
  localparam int HOLD_AT_B     = 330;
  localparam int PRINT_CAP     = 100;
  localparam int RAND_PHASES   = 13;
  localparam int WIN_SET_N     = 12;
  localparam int WIN_SET_AW    = $clog2(WIN_SET_N);
  localparam logic [wer_pkg::PRICE_W-1:0] PRICE_TOP = {wer_pkg::PRICE_W{1'b1}};

  // Window settings walked by the random phases; the last phase draws one
  localparam logic [wer_pkg::WIN_W-1:0] WIN_SET [WIN_SET_N] = '{
    7'd16, 7'd3, 7'd127, 7'd65, 7'd64, 7'd4, 7'd2, 7'd0, 7'd63, 7'd1, 7'd5, 7'd0
  };

  typedef struct packed {
    logic signed [wer_pkg::RATIO_W-1:0] ratio;
    logic        [wer_pkg::SIZE_W-1:0]  size;
  } er_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                          kind;
    logic        [wer_pkg::PRICE_W-1:0] value;   // price, or window value for ROW_CFG
    logic                               typed;   // use the expectation below
    logic signed [wer_pkg::RATIO_W-1:0] ratio;
    logic        [wer_pkg::SIZE_W-1:0]  size;
  } dir_row_t;

  typedef enum int {PM_RANDOM, PM_WALK, PM_TREND, PM_FLAT, PM_EXTREME} price_mode_e;

  // Directed samples: flat window, full rise, full fall, bit patterns and
  // window values at and beyond both ends of the legal range
  dir_row_t dir_rows [26] = '{
    '{ROW_ITEM, 24'h000000, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h000000, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h000000, 1'b1, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'hFFFFFF, 1'b1, 16'sd32767, 12'd2560},
    '{ROW_ITEM, 24'h000000, 1'b1, 16'sd0,     12'd0},
    '{ROW_CFG,  24'd3,      1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'hFFFFFF, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h800000, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h400000, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h000000, 1'b1, 16'h8000,   12'd2560},
    '{ROW_CFG,  24'd0,      1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h000001, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h123456, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h555555, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'hAAAAAA, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'hFEDCBA, 1'b0, 16'sd0,     12'd0},
    '{ROW_CFG,  24'd127,    1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h7FFFFF, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h800000, 1'b0, 16'sd0,     12'd0},
    '{ROW_CFG,  24'd2,      1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h0F0F0F, 1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'hF0F0F0, 1'b0, 16'sd0,     12'd0},
    '{ROW_CFG,  24'd64,     1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'h333333, 1'b0, 16'sd0,     12'd0},
    '{ROW_CFG,  24'd1,      1'b0, 16'sd0,     12'd0},
    '{ROW_ITEM, 24'hCCCCCC, 1'b0, 16'sd0,     12'd0}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [wer_pkg::WIN_W-1:0] cfg_wdata_i;

  wer_price_if  price_ch ();
  wer_result_if result_ch ();

  windowed_efficiency_ratio u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .price_i     (price_ch),
    .result_o    (result_ch)
  );

  // Predictor state
  logic [wer_pkg::PRICE_W-1:0] price_hist [HIST_DEPTH];
  int unsigned                 hist_wr    = 0;
  int unsigned                 samples_in = 0;
  logic [wer_pkg::WIN_W-1:0]   window_reg = wer_pkg::WIN_W'(wer_pkg::DEFAULT_WINDOW);

  er_result_t pending_results [$];
  int         mismatches   = 0;
  int         results_seen = 0;
  int         cycle_count  = 0;
  bit         tx_calm      = 1'b0;
  bit         rx_calm      = 1'b0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [wer_pkg::PRICE_W-1:0] hist_back(int unsigned k);
    return price_hist[HIST_AW'((hist_wr + HIST_DEPTH - 1 - k) % HIST_DEPTH)];
  endfunction

  // Store one sample and compute the ratio over the current window
  function automatic bit predict_efficiency(input logic [wer_pkg::PRICE_W-1:0] p,
                                            output er_result_t res);
    int unsigned n;
    int unsigned cnt;
    logic [63:0] a, b, newest, oldest, den, mag, q, sz, rv;
    bit          neg;
    res = '0;
    price_hist[HIST_AW'(hist_wr)] = p;
    hist_wr = (hist_wr + 1) % HIST_DEPTH;
    if (samples_in < MAX_WIN + 2) samples_in++;
    if (samples_in < 3) return 1'b0;

    n = 32'(window_reg);
    if (n < wer_pkg::MIN_WINDOW) n = wer_pkg::DEFAULT_WINDOW;
    if (n > MAX_WIN) n = MAX_WIN;
    cnt = samples_in - 2;
    if (cnt > n) cnt = n;

    // Sum absolute changes across the window
    den = '0;
    for (int unsigned k = 0; k < cnt; k++) begin
      a = 64'(hist_back(k));
      b = 64'(hist_back(k + 1));
      den += (a >= b) ? (a - b) : (b - a);
    end

    newest = 64'(hist_back(0));
    oldest = 64'(hist_back(cnt));
    neg = newest < oldest;
    mag = neg ? (oldest - newest) : (newest - oldest);

    // Flat window leaves both fields at zero
    if (den != 0) begin
      q = (mag << 15) / den;
      if (q > 64'd32768) q = 64'd32768;
      rv = neg ? (64'd0 - q)
               : ((q > 64'(wer_pkg::RATIO_MAX)) ? 64'(wer_pkg::RATIO_MAX) : q);
      res.ratio = rv[wer_pkg::RATIO_W-1:0];
      sz = (mag * 64'd2560) / den;
      if (sz > 64'(wer_pkg::SIZE_MAX)) sz = 64'(wer_pkg::SIZE_MAX);
      res.size = sz[wer_pkg::SIZE_W-1:0];
    end
    return 1'b1;
  endfunction

  function automatic logic [wer_pkg::PRICE_W-1:0] next_price(
      price_mode_e m, logic [wer_pkg::PRICE_W-1:0] prev, bit up);
    int v;
    v = int'(prev);
    case (m)
      PM_RANDOM:  v = int'($urandom_range(0, PRICE_TOP));
      PM_WALK:    v = v + int'($urandom_range(0, 512)) - 256;
      PM_TREND:   v = up ? v + int'($urandom_range(0, 65535))
                         : v - int'($urandom_range(0, 65535));
      PM_FLAT:    if ($urandom_range(0, 7) == 0) v = v + int'($urandom_range(0, 2)) - 1;
      PM_EXTREME: v = $urandom_range(0, 1) ? int'(PRICE_TOP) : 0;
      default:    v = 0;
    endcase
    if (v < 0) v = 0;
    if (v > int'(PRICE_TOP)) v = int'(PRICE_TOP);
    return v[wer_pkg::PRICE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offer one sample, hold it until the transfer, then queue its expectation
  task automatic push_price(input logic [wer_pkg::PRICE_W-1:0] p, input bit fixed,
                            input er_result_t fixed_res);
    int         gap;
    bit         has;
    er_result_t res;
    gap = tx_calm ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      price_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    price_ch.valid <= 1'b1;
    price_ch.price <= p;
    @(posedge clk_i);
    while (!price_ch.ready) @(posedge clk_i);
    has = predict_efficiency(p, res);
    if (fixed) pending_results.push_back(fixed_res);
    else if (has) pending_results.push_back(res);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every result, then let the block go quiet
  task automatic settle_idle();
    price_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_window(input logic [wer_pkg::WIN_W-1:0] v);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    window_reg = v;
  endtask

  task automatic check_result(input logic signed [wer_pkg::RATIO_W-1:0] r,
                              input logic [wer_pkg::SIZE_W-1:0] s);
    er_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result ratio %0d size %0d", r, s));
      return;
    end
    want = pending_results.pop_front();
    if (r !== want.ratio)
      report_mismatch($sformatf("phase_ratio %0d, want %0d", r, want.ratio));
    if (s !== want.size)
      report_mismatch($sformatf("marker_size %0d, want %0d", s, want.size));
  endtask

  // Result side: random stalls, calm stretches and two long hold-offs
  initial begin
    int stall;
    int rx_seg;
    rx_seg = 20;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = rx_calm ? 0 : int'($urandom_range(0, 3));
      if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) stall += HOLD_CYCLES;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_ch.valid) @(posedge clk_i);
      check_result(result_ch.phase_ratio, result_ch.marker_size);
      results_seen++;
      rx_seg--;
      if (rx_seg <= 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        rx_seg  = int'($urandom_range(10, 40));
      end
      @(negedge clk_i);
    end
  end

  // Stimulus
  initial begin
    er_result_t                  fixed_res;
    price_mode_e                 mode;
    logic [wer_pkg::PRICE_W-1:0] last_price;
    logic [wer_pkg::WIN_W-1:0]   new_win;
    int                          seg_left;
    int                          n_items;
    bit                          trend_up;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    price_ch.valid = 1'b0;
    price_ch.price = '0;
    mode           = PM_RANDOM;
    last_price     = PRICE_TOP >> 1;
    seg_left       = 0;
    trend_up       = 1'b1;

    // Hold reset, then release it
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_window(dir_rows[i].value[wer_pkg::WIN_W-1:0]);
      end else begin
        fixed_res.ratio = dir_rows[i].ratio;
        fixed_res.size  = dir_rows[i].size;
        push_price(dir_rows[i].value, dir_rows[i].typed, fixed_res);
      end
    end

    // Random phases, one window setting each
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      new_win = (ph < WIN_SET_N) ? WIN_SET[WIN_SET_AW'(ph)]
                                 : wer_pkg::WIN_W'($urandom_range(0, 127));
      write_window(new_win);
      tx_calm = ($urandom_range(0, 3) == 0);
      n_items = int'($urandom_range(30, 45));
      for (int i = 0; i < n_items; i++) begin
        if (seg_left == 0) begin
          mode     = price_mode_e'($urandom_range(0, 4));
          seg_left = int'($urandom_range(4, 24));
          trend_up = 1'($urandom_range(0, 1));
        end
        seg_left--;
        last_price = next_price(mode, last_price, trend_up);
        push_price(last_price, 1'b0, '0);
      end
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
